// ===== design/nrle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nibble run-length tile decoder.
// No dependencies; used by nrle_merge and nibble_rle_tile_decoder.
package nrle_pkg;

    localparam int WORD_W         = 32;
    localparam int IDX_W          = 13;
    localparam int WCNT_W         = 14;
    localparam int NIB_W          = 4;
    localparam int NIBS_PER_WORD  = 8;
    localparam int WORDS_PER_TILE = 4;
    localparam int REPS_W         = 5;   // 1..16 repeats
    localparam int TAKE_W         = 4;   // 1..8 nibbles merged per step
    localparam int REM_W          = 7;   // up to 64 nibbles per item

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WCNT_W-1:0] wcnt_t;
    typedef logic [REPS_W-1:0] reps_t;
    typedef logic [TAKE_W-1:0] take_t;
    typedef logic [REM_W-1:0]  rem_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Result of one merge step of the shared shift unit
    typedef struct packed {
        word_t      acc;    // accumulator after the merge
        logic [2:0] count;  // nibble count after the merge, modulo eight
        take_t      take;   // nibbles merged in this step
        logic       full;   // the merge completed a word
    } merge_t;

endpackage

// ===== design/nrle_merge.sv =====
`timescale 1ns / 1ps
// Shared shift unit: merges as many repeats of one value nibble as fit
// into the accumulator in one step. Depends on nrle_pkg.
module nrle_merge (
    input  nrle_pkg::word_t  acc,
    input  logic [2:0]       count,
    input  nrle_pkg::reps_t  reps,
    input  logic [3:0]       val,
    output nrle_pkg::merge_t res
);

    logic [3:0]      space;
    nrle_pkg::take_t take;
    logic [5:0]      shamt;
    nrle_pkg::word_t fill_mask;
    logic [3:0]      sum;

    always_comb begin
        space = 4'(nrle_pkg::NIBS_PER_WORD) - {1'b0, count};
        // take the whole run, or just what is left of the current word
        if (reps < {1'b0, space}) begin
            take = reps[3:0];
        end else begin
            take = space;
        end
        shamt     = {take, 2'b00};
        fill_mask = ~({nrle_pkg::WORD_W{1'b1}} << shamt);
        sum       = {1'b0, count} + take;

        res.acc   = (acc << shamt) | ({(nrle_pkg::WORD_W / nrle_pkg::NIB_W){val}} & fill_mask);
        res.count = sum[2:0];
        res.take  = take;
        res.full  = sum[3];
    end

endmodule

// ===== design/nibble_rle_tile_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the nibble run-length tile decoder: sequencer, counters,
// output register. Depends on nrle_pkg and nrle_merge.
//
//  channel  | ports               | payload
//  ---------+---------------------+---------------------------------------------
//  input    | s_tvalid/s_tready   | s_tdata[31:0] packed_word, s_tuser[0] first
//  result   | m_tvalid/m_tready   | m_tdata[31:0] out_word, [44:32] word_index,
//           |                     | m_tlast last, m_tuser[0] limit_reached
//  config   | cfg_valid/cfg_ready | cfg_data[13:0] total_words
//
// An item is accepted, then merged in one merge step per run segment: a coded
// byte costs one step, plus one per word it completes before its run ends; an
// item that arrives while stopped is accepted and not merged.
// A completed word waits in the output register; a stalled result channel
// holds the sequencer on the step that would complete the next word.
// Reset is synchronous on aresetn low and clears counters, limit and state.
module nibble_rle_tile_decoder #(
    parameter int MAX_TILES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] packed_word
    input  logic [0:0]  s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] out_word, [44:32] word_index, rest zero
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] limit_reached
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data   // [13:0] total_words
);

    localparam nrle_pkg::wcnt_t WORD_CAP =
        nrle_pkg::wcnt_t'(MAX_TILES * nrle_pkg::WORDS_PER_TILE);

    nrle_pkg::state_t state_reg, state_next;
    nrle_pkg::word_t  acc_reg, acc_next;
    logic [2:0]       count_reg, count_next;
    nrle_pkg::wcnt_t  words_reg, words_next;
    logic             done_reg, done_next;
    nrle_pkg::word_t  code_reg, code_next;
    logic [1:0]       byte_reg, byte_next;
    nrle_pkg::reps_t  reps_reg, reps_next;
    nrle_pkg::rem_t   rem_reg, rem_next;
    nrle_pkg::wcnt_t  total_reg;

    logic             out_valid_reg, out_valid_next;
    nrle_pkg::word_t  out_word_reg, out_word_next;
    nrle_pkg::idx_t   out_idx_reg, out_idx_next;
    logic             out_last_reg, out_last_next;
    logic             out_limit_reg, out_limit_next;

    nrle_pkg::merge_t mrg;
    nrle_pkg::wcnt_t  limit;
    nrle_pkg::wcnt_t  words_inc;
    nrle_pkg::reps_t  reps_after;
    nrle_pkg::rem_t   rem_after;
    logic             accept;
    logic             done_eff;
    logic             pre_limit;
    logic             post_limit;
    logic             emit;
    logic             step_go;
    logic             end_item;

    nrle_merge u_merge (
        .acc   (acc_reg),
        .count (count_reg),
        .reps  (reps_reg),
        .val   (code_reg[27:24]),
        .res   (mrg)
    );

    // Effective limit and the per-step decisions
    always_comb begin
        limit      = (total_reg < WORD_CAP) ? total_reg : WORD_CAP;
        words_inc  = words_reg + 1'b1;
        reps_after = reps_reg - {1'b0, mrg.take};
        rem_after  = rem_reg - nrle_pkg::rem_t'(mrg.take);
        accept     = s_tvalid && s_tready;
        done_eff   = s_tuser[0] ? 1'b0 : done_reg;
        pre_limit  = words_reg >= limit;
        post_limit = words_inc >= limit;
        emit       = mrg.full && !pre_limit;
        step_go    = !(emit && out_valid_reg && !m_tready);
        end_item   = (mrg.full && (pre_limit || post_limit)) ||
                     ((reps_after == '0) && (byte_reg == 2'd3));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nrle_pkg::ST_IDLE: begin
                if (accept && !done_eff) begin
                    state_next = nrle_pkg::ST_RUN;
                end
            end
            nrle_pkg::ST_RUN: begin
                if (step_go && end_item) begin
                    state_next = nrle_pkg::ST_IDLE;
                end
            end
            default: state_next = nrle_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        s_tready       = (state_reg == nrle_pkg::ST_IDLE);
        acc_next       = acc_reg;
        count_next     = count_reg;
        words_next     = words_reg;
        done_next      = done_reg;
        code_next      = code_reg;
        byte_next      = byte_reg;
        reps_next      = reps_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_limit_next = out_limit_reg;

        unique case (state_reg)
            nrle_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0]) begin
                        acc_next   = '0;
                        count_next = '0;
                        words_next = '0;
                        done_next  = 1'b0;
                    end
                    code_next = s_tdata;
                    byte_next = '0;
                    reps_next = {1'b0, s_tdata[31:28]} + 1'b1;
                    rem_next  = nrle_pkg::rem_t'(s_tdata[31:28]) +
                                nrle_pkg::rem_t'(s_tdata[23:20]) +
                                nrle_pkg::rem_t'(s_tdata[15:12]) +
                                nrle_pkg::rem_t'(s_tdata[7:4]) + 7'd4;
                end
            end
            nrle_pkg::ST_RUN: begin
                if (step_go) begin
                    acc_next   = mrg.acc;
                    count_next = mrg.count;
                    rem_next   = rem_after;
                    if (mrg.full) begin
                        if (pre_limit) begin
                            // limit already met: drop the rest of the item
                            done_next = 1'b1;
                        end else begin
                            out_valid_next = 1'b1;
                            out_word_next  = mrg.acc;
                            out_idx_next   = words_reg[nrle_pkg::IDX_W-1:0];
                            out_limit_next = post_limit;
                            out_last_next  = post_limit ||
                                             (rem_after < nrle_pkg::rem_t'(nrle_pkg::NIBS_PER_WORD));
                            words_next     = words_inc;
                            acc_next       = '0;
                            done_next      = post_limit;
                        end
                    end
                    reps_next = reps_after;
                    if (reps_after == '0 && byte_reg != 2'd3) begin
                        // advance to the next coded byte
                        byte_next = byte_reg + 1'b1;
                        code_next = {code_reg[23:0], 8'h00};
                        reps_next = {1'b0, code_reg[23:20]} + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= nrle_pkg::ST_IDLE;
            acc_reg       <= '0;
            count_reg     <= '0;
            words_reg     <= '0;
            done_reg      <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            words_reg     <= words_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                total_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        code_reg      <= code_next;
        byte_reg      <= byte_next;
        reps_reg      <= reps_next;
        rem_reg       <= rem_next;
        out_word_reg  <= out_word_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
        out_limit_reg <= out_limit_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_idx_reg, out_word_reg};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_limit_reg;

endmodule

// ===== design/nrle_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the nibble run-length tile decoder, bound to the
// top level below. Depends only on the top level's ports.
module nrle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // the word that hits the limit is always the final one of its item
    a_limit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("limit word without last");

    // an item just taken cannot show a result in the next cycle
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result right after an accepted item");

    // padding above word_index stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:45] == 3'b000)
        else $error("nonzero padding in result item");

endmodule

bind nibble_rle_tile_decoder nrle_checker u_nrle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/nibble_rle_tile_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for nibble_rle_tile_decoder: scripted and random coded words,
// tile words checked against an in-bench run-length decoder. Depends on nrle_pkg.
module nibble_rle_tile_decoder_test;

    localparam int MAX_TILES    = 2048;
    localparam int MAX_WORDS    = MAX_TILES * nrle_pkg::WORDS_PER_TILE;
    localparam int SETTLE       = 30;     // covers the slowest item plus the output register
    localparam int STALL_LIMIT  = 2000;
    localparam int SCRIPT_ROWS  = 25;
    localparam int NUM_PHASES   = 8;
    localparam int SWEEP_ITEMS  = 30;

    typedef struct packed {
        nrle_pkg::word_t data;
        nrle_pkg::idx_t  index;
        logic            last;
        logic            at_limit;
    } tile_word_t;

    typedef struct packed {
        logic            is_cfg;   // row writes total_words instead of sending an item
        nrle_pkg::word_t data;
        logic            first;
        logic            typed;    // want holds the single tile word this item yields
        tile_word_t      want;
    } script_row_t;

    localparam tile_word_t NONE = '0;

    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        // limit of zero straight out of reset, no start mark
        '{1'b0, 32'h7A00_0000, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h1234_5678, 1'b0, 1'b0, NONE},
        '{1'b1, 32'h0000_3FFF, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h7A00_0000, 1'b1, 1'b1, '{32'hAAAA_AAAA, 13'd0, 1'b1, 1'b0}},
        '{1'b0, 32'hF500_0000, 1'b1, 1'b0, NONE},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h0000_0000, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h0123_4567, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h0F1E_2D3C, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h80C0_E0F0, 1'b1, 1'b0, NONE},
        '{1'b1, 32'h0000_0003, 1'b0, 1'b0, NONE},
        '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, NONE},
        '{1'b0, 32'h7A7B_7C7D, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h7C00_0000, 1'b1, 1'b1, '{32'hCCCC_CCCC, 13'd0, 1'b1, 1'b0}},
        '{1'b1, 32'h0000_0001, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h7E00_0000, 1'b1, 1'b1, '{32'hEEEE_EEEE, 13'd0, 1'b1, 1'b1}},
        '{1'b0, 32'h7E00_0000, 1'b0, 1'b0, NONE},
        '{1'b1, 32'h0000_0005, 1'b0, 1'b0, NONE},
        '{1'b0, 32'hF100_0000, 1'b1, 1'b0, NONE},
        // lower the limit below the words already written
        '{1'b1, 32'h0000_0001, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h7100_0000, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h7F00_0000, 1'b1, 1'b1, '{32'hFFFF_FFFF, 13'd0, 1'b1, 1'b1}},
        '{1'b1, 32'h0000_2000, 1'b0, 1'b0, NONE},
        '{1'b0, 32'h7D7D_7D7D, 1'b1, 1'b0, NONE},
        '{1'b0, 32'h00FF_00FF, 1'b0, 1'b0, NONE}
    };

    localparam int PHASE_LIMIT [NUM_PHASES] = '{0, 16383, 2, 8192, -1, 8193, -2, 1};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{6, 50, 30, 50, 45, 45, 50, 25};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [13:0] cfg_data = '0;

    // decoder state mirrored by the bench
    nrle_pkg::wcnt_t limit_words;
    nrle_pkg::word_t nib_acc;
    int              nib_count;
    int              words_out;
    bit              stopped;

    tile_word_t expected_words[$];
    tile_word_t decoded[$];
    int         mismatches = 0;
    bit         quiet = 1'b0;
    int         stall_left = 0;
    int         idle_cycles = 0;

    nibble_rle_tile_decoder #(
        .MAX_TILES(MAX_TILES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Expand one coded word into the tile words it completes; result in decoded.
    task automatic decode_runs(input nrle_pkg::word_t w, input logic first);
        int         cap;
        int         b;
        int         r;
        int         reps;
        logic [7:0] code;
        tile_word_t tw;
        decoded.delete();
        cap = (limit_words < MAX_WORDS) ? int'(limit_words) : MAX_WORDS;
        if (first) begin
            nib_acc   = '0;
            nib_count = 0;
            words_out = 0;
            stopped   = 1'b0;
        end
        if (stopped) return;
        for (b = 0; b < 4 && !stopped; b++) begin
            code = w[31 - 8*b -: 8];
            reps = int'(code[7:4]) + 1;
            for (r = 0; r < reps; r++) begin
                nib_acc = {nib_acc[27:0], code[3:0]};
                nib_count++;
                if (nib_count == nrle_pkg::NIBS_PER_WORD) begin
                    if (words_out >= cap) begin
                        stopped = 1'b1;
                        break;
                    end
                    tw.data   = nib_acc;
                    tw.index  = nrle_pkg::idx_t'(words_out);
                    tw.last   = 1'b0;
                    words_out = (words_out + 1) & 16'h3FFF;
                    tw.at_limit = (words_out >= cap);
                    decoded.push_back(tw);
                    nib_acc   = '0;
                    nib_count = 0;
                    if (words_out >= cap) begin
                        stopped = 1'b1;
                        break;
                    end
                end
            end
        end
        if (decoded.size() > 0) begin
            tw = decoded[decoded.size() - 1];
            tw.last = 1'b1;
            decoded[decoded.size() - 1] = tw;
        end
    endtask

    // Offer one item, optionally after an idle burst; hold valid high on return.
    task automatic send_item(input nrle_pkg::word_t w, input logic first,
                             input tile_word_t want, input logic typed);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        decode_runs(w, first);
        if (typed)
            expected_words.push_back(want);
        else
            foreach (decoded[i]) expected_words.push_back(decoded[i]);
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_limit(input nrle_pkg::wcnt_t v);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        limit_words = v;
    endtask

    function automatic nrle_pkg::word_t pick_word();
        nrle_pkg::word_t w;
        int              b;
        int              mode;
        w    = $urandom();
        mode = $urandom_range(0, 3);
        for (b = 0; b < 4; b++) begin
            case (mode)
                1:       w[8*b + 4 +: 4] = 4'($urandom_range(0, 1));
                2:       w[8*b + 4 +: 4] = 4'($urandom_range(12, 15));
                3:       w[8*b + 4 +: 4] = 4'd7;
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic check_result();
        tile_word_t want;
        tile_word_t got;
        got.data     = m_tdata[31:0];
        got.index    = m_tdata[44:32];
        got.last     = m_tlast;
        got.at_limit = m_tuser[0];
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected tile word: data=%h index=%0d last=%b limit=%b",
                         got.data, got.index, got.last, got.at_limit);
        end else begin
            want = expected_words.pop_front();
            if (got.data !== want.data || got.index !== want.index ||
                got.last !== want.last || got.at_limit !== want.at_limit) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tile word mismatch: exp data=%h index=%0d last=%b limit=%b, %s",
                             want.data, want.index, want.last, want.at_limit,
                             $sformatf("got data=%h index=%0d last=%b limit=%b",
                                       got.data, got.index, got.last, got.at_limit));
            end
        end
    endtask

    // Result side: check each accepted tile word, stall ready in short bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result();
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int              ph;
        int              n;
        int              lim;
        nrle_pkg::word_t w;
        logic            first;
        limit_words = '0;
        nib_acc     = '0;
        nib_count   = 0;
        words_out   = 0;
        stopped     = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].is_cfg)
                write_limit(nrle_pkg::wcnt_t'(SCRIPT[i].data));
            else
                send_item(SCRIPT[i].data, SCRIPT[i].first, SCRIPT[i].want, SCRIPT[i].typed);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            lim = PHASE_LIMIT[ph];
            if (lim == -1) lim = $urandom_range(1, 40);
            if (lim == -2) lim = $urandom_range(0, 16383);
            write_limit(nrle_pkg::wcnt_t'(lim));
            for (n = 0; n < PHASE_ITEMS[ph]; n++) begin
                // restart often once the limit has stopped output
                if (n == 0 || stopped)
                    first = ($urandom_range(0, 1) == 0) || n == 0;
                else
                    first = ($urandom_range(0, 11) == 0);
                send_item(pick_word(), first, nrle_pkg::word_t'(0) == 0 ? NONE : NONE, 1'b0);
            end
        end

        // Finish back to back at the full limit: 64 nibbles per item, no idling.
        write_limit(14'h3FFF);
        quiet = 1'b1;
        for (n = 0; n < SWEEP_ITEMS; n++) begin
            w = $urandom();
            w[31:28] = 4'hF;
            w[23:20] = 4'hF;
            w[15:12] = 4'hF;
            w[7:4]   = 4'hF;
            send_item(w, n == 0, NONE, 1'b0);
        end
        drain_outputs();

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
